FILE: rtl/chtk_pkg.sv
// ----------------------------------------------------------------------------
// chtk_pkg
// shared constants and types of the caller histogram with top-k readout
// ----------------------------------------------------------------------------
package chtk_pkg;

    localparam int TABLE_SLOTS_DEF = 128;
    localparam int PROBE_LIMIT_DEF = 12;
    localparam int TOP_RANKS_DEF   = 6;

    localparam int ADDR_W       = 32;
    localparam int CNT_W        = 32;
    localparam int RANK_FIELD_W = 3;

    // key hashing drops the low address bits
    localparam int HASH_SHIFT  = 2;
    localparam int HASH_WORD_W = 32;
    localparam int HASH_BITS   = 8;
    localparam int HASH_CYCLES = HASH_WORD_W / HASH_BITS;
    localparam int HASH_CNT_W  = $clog2(HASH_CYCLES);

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [CNT_W-1:0]  count;
    } slot_t;

endpackage

FILE: rtl/chtk_req_if.sv
// ----------------------------------------------------------------------------
// chtk_req_if
// request channel: record a call or ask for a top-caller readout
// ----------------------------------------------------------------------------
interface chtk_req_if import chtk_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              kind;
    logic [ADDR_W-1:0] caller_address;

    modport source (output valid, output kind, output caller_address, input ready);
    modport sink   (input valid, input kind, input caller_address, output ready);

endinterface

FILE: rtl/chtk_rsp_if.sv
// ----------------------------------------------------------------------------
// chtk_rsp_if
// result channel: one word per reported rank
// ----------------------------------------------------------------------------
interface chtk_rsp_if import chtk_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [RANK_FIELD_W-1:0] rank;
    logic [ADDR_W-1:0]       caller_key;
    logic [CNT_W-1:0]        hit_count;
    logic [CNT_W-1:0]        total_calls;
    logic                    found;
    logic                    last;

    modport source (
        output valid, output rank, output caller_key, output hit_count,
        output total_calls, output found, output last, input ready
    );
    modport sink (
        input valid, input rank, input caller_key, input hit_count,
        input total_calls, input found, input last, output ready
    );

endinterface

FILE: rtl/chtk_slot_ram.sv
// ----------------------------------------------------------------------------
// chtk_slot_ram
// slot table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module chtk_slot_ram import chtk_pkg::*; #(
    parameter int  DEPTH = TABLE_SLOTS_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output slot_t         rd_data
);

    slot_t mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/caller_histogram_top_k_core.sv
// ----------------------------------------------------------------------------
// caller_histogram_top_k_core
// call histogram keyed by caller address, with a hottest-first readout
// ----------------------------------------------------------------------------
// req carries one word per request: kind record bumps the total call counter
// and counts the caller in an open-addressed slot table (linear probing, at
// most PROBE_LIMIT slots); kind readout returns up to TOP_RANKS words on rsp,
// hottest first, the final one flagged last. An empty table gives a single
// word with found clear.
// A record probes k slots (1 to PROBE_LIMIT) before the next request can be
// accepted; when TABLE_SLOTS is not a power of two the home slot is first
// reduced 8 bits a cycle. The single read port of the slot table allows one
// probe per cycle. A readout does one full table scan per rank, then a final
// flush step hands over the last word; with fewer than TOP_RANKS slots in
// use, one more scan that finds nothing ends the readout instead.
// After reset the block clears the hit counts, one slot a cycle, through the
// whole table; req.ready stays low meanwhile.
// Results sit in an output register; a stalled receiver holds the readout
// at the next word, and a record may be accepted while the last word waits.
// ----------------------------------------------------------------------------
module caller_histogram_top_k_core import chtk_pkg::*; #(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int PROBE_LIMIT = PROBE_LIMIT_DEF,
    parameter int TOP_RANKS   = TOP_RANKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    chtk_req_if.sink    req,
    chtk_rsp_if.source  rsp
);

    localparam int   IDX_W   = $clog2(TABLE_SLOTS);
    localparam int   REM_W   = IDX_W + 1;
    localparam int   PRB_W   = $clog2(PROBE_LIMIT + 1);
    localparam int   RANK_W  = $clog2(TOP_RANKS + 1);
    localparam logic IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_HASH      = 4'd2;
    localparam logic [3:0] ST_PROBE_RD  = 4'd3;
    localparam logic [3:0] ST_PROBE_CHK = 4'd4;
    localparam logic [3:0] ST_SCAN      = 4'd5;
    localparam logic [3:0] ST_SCAN_LAST = 4'd6;
    localparam logic [3:0] ST_SCAN_DONE = 4'd7;
    localparam logic [3:0] ST_FLUSH     = 4'd8;

    // control state
    logic [3:0]            state_reg, state_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]      call_total_reg, call_total_next;
    logic [HASH_CNT_W-1:0] hash_cnt_reg, hash_cnt_next;
    logic [PRB_W-1:0]      probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic                  best_vld_reg, best_vld_next;
    logic                  thr_vld_reg, thr_vld_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic                  rsp_vld_reg, rsp_vld_next;

    // payload
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [HASH_WORD_W-1:0] hash_word_reg, hash_word_next;
    logic [IDX_W-1:0]       hash_rem_reg, hash_rem_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]       best_cnt_reg, best_cnt_next;
    logic [ADDR_W-1:0]      best_key_reg, best_key_next;
    logic [IDX_W-1:0]       thr_idx_reg, thr_idx_next;
    logic [CNT_W-1:0]       thr_cnt_reg, thr_cnt_next;
    logic [RANK_W-1:0]      pend_rank_reg, pend_rank_next;
    logic [ADDR_W-1:0]      pend_key_reg, pend_key_next;
    logic [CNT_W-1:0]       pend_cnt_reg, pend_cnt_next;

    logic [RANK_FIELD_W-1:0] rsp_rank_reg, rsp_rank_next;
    logic [ADDR_W-1:0]       rsp_key_reg, rsp_key_next;
    logic [CNT_W-1:0]        rsp_cnt_reg, rsp_cnt_next;
    logic [CNT_W-1:0]        rsp_total_reg, rsp_total_next;
    logic                    rsp_found_reg, rsp_found_next;
    logic                    rsp_last_reg, rsp_last_next;

    // slot table port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    slot_t            rd_data;

    logic                  out_free;
    logic                  load_out;
    logic                  out_from_pend;
    logic                  out_last;
    logic                  cand;
    logic                  better;
    logic [IDX_W-1:0]      slot_inc;
    logic [REM_W-1:0]      hash_step;
    logic [RANK_W+2:0]     pend_rank_wide;

    chtk_slot_ram #(
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign out_free  = !rsp_vld_reg || rsp.ready;
    assign slot_inc  = (slot_reg == IDX_W'(TABLE_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
    assign pend_rank_wide = {3'b000, pend_rank_reg};

    // eight restoring steps of (addr >> 2) mod TABLE_SLOTS, msb first
    always_comb
    begin
        hash_step = {1'b0, hash_rem_reg};
        for (int b = 0; b < HASH_BITS; b++)
        begin
            hash_step = {hash_step[REM_W-2:0], hash_word_reg[HASH_WORD_W-1-b]};
            if (hash_step >= REM_W'(TABLE_SLOTS))
            begin
                hash_step = hash_step - REM_W'(TABLE_SLOTS);
            end
        end
    end

    // slot rank order: higher count first, lower index on ties;
    // a candidate comes strictly after the previously reported slot
    assign cand = (rd_data.count != '0) &&
                  (!thr_vld_reg || (rd_data.count < thr_cnt_reg) ||
                   ((rd_data.count == thr_cnt_reg) && (cmp_idx_reg > thr_idx_reg)));
    assign better = cand && (!best_vld_reg || (rd_data.count > best_cnt_reg));

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        call_total_next = call_total_reg;
        hash_cnt_next   = hash_cnt_reg;
        probe_cnt_next  = probe_cnt_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_vld_next    = 1'b0;
        best_vld_next   = best_vld_reg;
        thr_vld_next    = thr_vld_reg;
        pend_vld_next   = pend_vld_reg;
        rank_next       = rank_reg;
        addr_next       = addr_reg;
        slot_next       = slot_reg;
        hash_word_next  = hash_word_reg;
        hash_rem_next   = hash_rem_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        best_key_next   = best_key_reg;
        thr_idx_next    = thr_idx_reg;
        thr_cnt_next    = thr_cnt_reg;
        pend_rank_next  = pend_rank_reg;
        pend_key_next   = pend_key_reg;
        pend_cnt_next   = pend_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = slot_reg;
        load_out        = 1'b0;
        out_from_pend   = 1'b0;
        out_last        = 1'b0;

        if (cmp_vld_reg && better)
        begin
            best_vld_next = 1'b1;
            best_idx_next = cmp_idx_reg;
            best_cnt_next = rd_data.count;
            best_key_next = rd_data.key;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.kind == KIND_RECORD)
                    begin
                        call_total_next = call_total_reg + 1'b1;
                        addr_next       = req.caller_address;
                        hash_word_next  = HASH_WORD_W'(req.caller_address >> HASH_SHIFT);
                        hash_rem_next   = '0;
                        hash_cnt_next   = '0;
                        slot_next       = req.caller_address[HASH_SHIFT +: IDX_W];
                        state_next      = IS_POW2 ? ST_PROBE_RD : ST_HASH;
                    end
                    else
                    begin
                        scan_addr_next = '0;
                        best_vld_next  = 1'b0;
                        thr_vld_next   = 1'b0;
                        pend_vld_next  = 1'b0;
                        rank_next      = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_HASH:
            begin
                hash_rem_next  = hash_step[IDX_W-1:0];
                hash_word_next = hash_word_reg << HASH_BITS;
                hash_cnt_next  = hash_cnt_reg + 1'b1;
                if (hash_cnt_reg == HASH_CNT_W'(HASH_CYCLES - 1))
                begin
                    slot_next  = hash_step[IDX_W-1:0];
                    state_next = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                rd_en          = 1'b1;
                rd_addr        = slot_reg;
                probe_cnt_next = '0;
                state_next     = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                if (rd_data.count == '0)
                begin
                    wr_en      = 1'b1;
                    wr_data    = '{key: addr_reg, count: CNT_W'(1)};
                    state_next = ST_IDLE;
                end
                else if (rd_data.key == addr_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = '{key: addr_reg, count: rd_data.count + 1'b1};
                    state_next = ST_IDLE;
                end
                else if (probe_cnt_reg == PRB_W'(PROBE_LIMIT - 1))
                begin
                    // probe run exhausted, call only shows in the total
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = slot_inc;
                    slot_next      = slot_inc;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                rd_en        = 1'b1;
                rd_addr      = scan_addr_reg;
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_addr_reg;
                if (scan_addr_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_SCAN_LAST;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            ST_SCAN_LAST:
            begin
                state_next = ST_SCAN_DONE;
            end
            ST_SCAN_DONE:
            begin
                if (out_free)
                begin
                    if (best_vld_reg)
                    begin
                        // the previous pick is known not to be last now
                        load_out       = pend_vld_reg;
                        out_from_pend  = 1'b1;
                        pend_vld_next  = 1'b1;
                        pend_rank_next = rank_reg;
                        pend_key_next  = best_key_reg;
                        pend_cnt_next  = best_cnt_reg;
                        thr_vld_next   = 1'b1;
                        thr_idx_next   = best_idx_reg;
                        thr_cnt_next   = best_cnt_reg;
                        if (rank_reg == RANK_W'(TOP_RANKS - 1))
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            rank_next      = rank_reg + 1'b1;
                            scan_addr_next = '0;
                            best_vld_next  = 1'b0;
                            state_next     = ST_SCAN;
                        end
                    end
                    else
                    begin
                        // pending pick is final, or empty table word
                        load_out      = 1'b1;
                        out_from_pend = pend_vld_reg;
                        out_last      = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    out_from_pend = 1'b1;
                    out_last      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_vld_next   = load_out || (rsp_vld_reg && !rsp.ready);
        rsp_rank_next  = out_from_pend ? pend_rank_wide[RANK_FIELD_W-1:0] : '0;
        rsp_key_next   = out_from_pend ? pend_key_reg : '0;
        rsp_cnt_next   = out_from_pend ? pend_cnt_reg : '0;
        rsp_total_next = call_total_reg;
        rsp_found_next = out_from_pend;
        rsp_last_next  = out_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            call_total_reg <= '0;
            hash_cnt_reg   <= '0;
            probe_cnt_reg  <= '0;
            scan_addr_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            best_vld_reg   <= 1'b0;
            thr_vld_reg    <= 1'b0;
            pend_vld_reg   <= 1'b0;
            rank_reg       <= '0;
            rsp_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            call_total_reg <= call_total_next;
            hash_cnt_reg   <= hash_cnt_next;
            probe_cnt_reg  <= probe_cnt_next;
            scan_addr_reg  <= scan_addr_next;
            cmp_vld_reg    <= cmp_vld_next;
            best_vld_reg   <= best_vld_next;
            thr_vld_reg    <= thr_vld_next;
            pend_vld_reg   <= pend_vld_next;
            rank_reg       <= rank_next;
            rsp_vld_reg    <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        slot_reg      <= slot_next;
        hash_word_reg <= hash_word_next;
        hash_rem_reg  <= hash_rem_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_cnt_reg  <= best_cnt_next;
        best_key_reg  <= best_key_next;
        thr_idx_reg   <= thr_idx_next;
        thr_cnt_reg   <= thr_cnt_next;
        pend_rank_reg <= pend_rank_next;
        pend_key_reg  <= pend_key_next;
        pend_cnt_reg  <= pend_cnt_next;
        if (load_out)
        begin
            rsp_rank_reg  <= rsp_rank_next;
            rsp_key_reg   <= rsp_key_next;
            rsp_cnt_reg   <= rsp_cnt_next;
            rsp_total_reg <= rsp_total_next;
            rsp_found_reg <= rsp_found_next;
            rsp_last_reg  <= rsp_last_next;
        end
    end

    assign rsp.valid       = rsp_vld_reg;
    assign rsp.rank        = rsp_rank_reg;
    assign rsp.caller_key  = rsp_key_reg;
    assign rsp.hit_count   = rsp_cnt_reg;
    assign rsp.total_calls = rsp_total_reg;
    assign rsp.found       = rsp_found_reg;
    assign rsp.last        = rsp_last_reg;

    a_empty_word_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && !rsp_found_reg |-> rsp_last_reg && (rsp_rank_reg == '0))
        else $error("empty-table word not a lone final word");

    a_total_on_record: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.kind == KIND_RECORD)
        |=> call_total_reg == $past(call_total_reg) + 1'b1)
        else $error("call total not bumped by a record");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) || (state_reg == ST_SCAN_LAST) || (state_reg == ST_SCAN_DONE)
        |-> !wr_en)
        else $error("slot table written during a readout scan");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && !rsp.ready |-> !load_out)
        else $error("held result word overwritten");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE_CHK |-> probe_cnt_reg < PRB_W'(PROBE_LIMIT))
        else $error("probe run past its limit");

endmodule

FILE: verif/tb_caller_histogram_top_k_core.sv
// ----------------------------------------------------------------------------
// tb_caller_histogram_top_k_core
// self-checking bench for the caller histogram with hottest-first readout
// ----------------------------------------------------------------------------
// A clocked driver feeds record and readout words from a stimulus queue and
// updates a local copy of the slot table on every accepted record. Readouts
// push the predicted rank words, and a clocked monitor checks each accepted
// result word against the oldest prediction. Both sides idle at random; the
// receiver also holds off for a long stretch so the core backs up.
// ----------------------------------------------------------------------------
module tb_caller_histogram_top_k_core;
    import chtk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS  = TABLE_SLOTS_DEF;
    localparam int PROBES = PROBE_LIMIT_DEF;
    localparam int RANKS  = TOP_RANKS_DEF;
    localparam int POOL_N = 40;

    typedef struct {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        bit                drain;   // wait for all results before offering
        bit                steady;  // no idle cycle after this word
    } call_word_t;

    typedef struct {
        logic [RANK_FIELD_W-1:0] rank;
        logic [ADDR_W-1:0]       key;
        logic [CNT_W-1:0]        hits;
        logic [CNT_W-1:0]        total;
        logic                    found;
        logic                    last;
    } rank_word_t;

    logic clk;
    logic rst_n;

    chtk_req_if req_ch ();
    chtk_rsp_if rsp_ch ();

    caller_histogram_top_k_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // local copy of the histogram
    logic [ADDR_W-1:0] hist_keys   [SLOTS];
    logic [CNT_W-1:0]  hist_counts [SLOTS];
    logic [CNT_W-1:0]  call_tally;

    call_word_t call_words [$];
    rank_word_t rank_queue [$];

    int  fails = 0;
    int  readouts_issued = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  hold_rsp = 1'b0;
    bit  rsp_steady = 1'b0;

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_RECORD;
        req_ch.caller_address = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hist_keys[i] = '0;
            hist_counts[i] = '0;
        end
        call_tally = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_call(logic kind, logic [ADDR_W-1:0] addr,
                                       bit drain, bit steady);
        call_word_t w;
        w.kind = kind;
        w.addr = addr;
        w.drain = drain;
        w.steady = steady;
        call_words.push_back(w);
    endfunction

    task automatic tally_call(input logic [ADDR_W-1:0] addr);
        int home;
        int s;
        home = int'((addr >> HASH_SHIFT) % SLOTS);
        call_tally = call_tally + 1'b1;
        for (int i = 0; i < PROBES; i++)
        begin
            s = (home + i) % SLOTS;
            if (hist_counts[s] == '0)
            begin
                hist_keys[s] = addr;
                hist_counts[s] = 1;
                return;
            end
            if (hist_keys[s] == addr)
            begin
                hist_counts[s] = hist_counts[s] + 1'b1;
                return;
            end
        end
        // no slot on the probe path: only the total sees this call
    endtask

    task automatic rank_hottest();
        bit         taken [SLOTS];
        int         best;
        rank_word_t w;
        rank_word_t words [$];
        foreach (taken[i])
            taken[i] = 1'b0;
        for (int r = 0; r < RANKS; r++)
        begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (hist_counts[i] != '0 && !taken[i])
                begin
                    // strict compare keeps ties on the lower index
                    if (best < 0 || hist_counts[i] > hist_counts[best])
                        best = i;
                end
            end
            if (best < 0)
                break;
            taken[best] = 1'b1;
            w.rank = RANK_FIELD_W'(r);
            w.key = hist_keys[best];
            w.hits = hist_counts[best];
            w.total = call_tally;
            w.found = 1'b1;
            w.last = 1'b0;
            words.push_back(w);
        end
        if (words.size() == 0)
        begin
            w.rank = '0;
            w.key = '0;
            w.hits = '0;
            w.total = call_tally;
            w.found = 1'b0;
            w.last = 1'b1;
            words.push_back(w);
        end
        else
            words[words.size()-1].last = 1'b1;
        foreach (words[i])
            rank_queue.push_back(words[i]);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.kind == KIND_RECORD)
                    tally_call(req_ch.caller_address);
                else
                begin
                    rank_hottest();
                    readouts_issued++;
                end
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (call_words.size() > 0 &&
                         !(call_words[0].drain && rank_queue.size() > 0))
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.kind <= call_words[0].kind;
                    req_ch.caller_address <= call_words[0].addr;
                    send_gap = call_words[0].steady ? 0 : idle_len();
                    void'(call_words.pop_front());
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rank_word_t e;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rank_queue.size() == 0)
                begin
                    $error("result word with nothing pending: rank %0d key %h",
                           rsp_ch.rank, rsp_ch.caller_key);
                    fails++;
                end
                else
                begin
                    e = rank_queue.pop_front();
                    if (rsp_ch.rank !== e.rank)
                    begin
                        $error("rank mismatch: expected %0d, got %0d", e.rank, rsp_ch.rank);
                        fails++;
                    end
                    if (rsp_ch.caller_key !== e.key)
                    begin
                        $error("caller_key mismatch: expected %h, got %h",
                               e.key, rsp_ch.caller_key);
                        fails++;
                    end
                    if (rsp_ch.hit_count !== e.hits)
                    begin
                        $error("hit_count mismatch: expected %0d, got %0d",
                               e.hits, rsp_ch.hit_count);
                        fails++;
                    end
                    if (rsp_ch.total_calls !== e.total)
                    begin
                        $error("total_calls mismatch: expected %0d, got %0d",
                               e.total, rsp_ch.total_calls);
                        fails++;
                    end
                    if (rsp_ch.found !== e.found)
                    begin
                        $error("found mismatch: expected %0d, got %0d", e.found, rsp_ch.found);
                        fails++;
                    end
                    if (rsp_ch.last !== e.last)
                    begin
                        $error("last mismatch: expected %0d, got %0d", e.last, rsp_ch.last);
                        fails++;
                    end
                end
            end
            if (hold_rsp)
                rsp_ch.ready <= 1'b0;
            else if (rsp_steady)
                rsp_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            end
        end
    end

    // long receiver hold-off, then a stretch with no receiver idling
    initial begin
        wait (readouts_issued >= 5);
        @(negedge clk);
        hold_rsp = 1'b1;
        repeat (2500) @(negedge clk);
        hold_rsp = 1'b0;
        rsp_steady = 1'b1;
        repeat (3000) @(negedge clk);
        rsp_steady = 1'b0;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] pool [POOL_N];
        logic [6:0]        homes [4];
        logic [ADDR_W-1:0] a;
        int                roll;

        // empty table readout
        queue_call(KIND_READOUT, 32'h0000_0000, 1'b0, 1'b0);
        queue_call(KIND_RECORD, 32'h0000_0000, 1'b0, 1'b0);
        queue_call(KIND_RECORD, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_call(KIND_RECORD, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // home in the top slot, probe wraps past the end of the table
        queue_call(KIND_RECORD, 32'hFFFF_FFFC, 1'b0, 1'b0);
        queue_call(KIND_RECORD, 32'h0000_0001, 1'b0, 1'b0);
        queue_call(KIND_READOUT, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // fill a whole probe path, then one more key gets dropped
        for (int k = 0; k < PROBES; k++)
            queue_call(KIND_RECORD, ((k + 1) << 9) | (32'h40 << 2), 1'b0, 1'b0);
        queue_call(KIND_RECORD, (PROBES + 1) << 9 | (32'h40 << 2), 1'b0, 1'b0);
        queue_call(KIND_READOUT, 32'h5555_AAAA, 1'b0, 1'b0);
        queue_call(KIND_RECORD, (1 << 9) | (32'h40 << 2), 1'b0, 1'b0);
        queue_call(KIND_READOUT, 32'h0000_0000, 1'b0, 1'b0);

        homes[0] = 7'd127;
        homes[1] = 7'd126;
        homes[2] = 7'($urandom_range(0, 127));
        homes[3] = 7'($urandom_range(0, 127));
        for (int j = 0; j < POOL_N; j++)
        begin
            a = $urandom;
            // half the keys crowd a few homes to force long probes
            if ($urandom_range(0, 1) == 1)
                a[8:2] = homes[$urandom_range(0, 3)];
            pool[j] = a;
        end

        for (int n = 0; n < 280; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                queue_call(KIND_READOUT, $urandom, n % 70 == 0, n >= 120 && n < 170);
            else if (roll < 72)
                queue_call(KIND_RECORD, pool[$urandom_range(0, $urandom_range(0, POOL_N - 1))],
                           n % 70 == 0, n >= 120 && n < 170);
            else
                queue_call(KIND_RECORD, $urandom, n % 70 == 0, n >= 120 && n < 170);
        end
        queue_call(KIND_READOUT, 32'h0000_0000, 1'b1, 1'b0);

        while (call_words.size() != 0 || req_ch.valid || rank_queue.size() != 0)
            @(negedge clk);
        repeat (1000) @(negedge clk);
        if (fails == 0 && rank_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
